/* rtl/dpc_pkg.sv */
// shared types and constants of the disk page cache
// no dependencies
package dpc_pkg;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [2:0] MAX_SIZE  = 3'd4;
  localparam logic [7:0] BYTE_MASK = 8'hFF;

  typedef struct packed {
    logic fill_done;
    logic fill_dirty;
    logic mark_dirty;
  } dpc_meta_upd_t;

endpackage

/* rtl/dpc_ram.sv */
// generic simple dual-port ram with registered read
// no dependencies
module dpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/dpc_meta.sv */
// line tag array: valid, dirty and page number of each cache line
// depends on dpc_pkg
module dpc_meta import dpc_pkg::*; #(
  parameter int CACHE_LINES = 8,
  parameter int IDX_W       = 3,
  parameter int PAGE_W      = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [IDX_W-1:0]  idx_i,
  input  logic [PAGE_W-1:0] page_i,
  input  dpc_meta_upd_t     upd_i,
  output logic              valid_o,
  output logic              dirty_o,
  output logic [PAGE_W-1:0] page_o
);

  logic              valid_q [CACHE_LINES];
  logic              dirty_q [CACHE_LINES];
  logic [PAGE_W-1:0] page_q  [CACHE_LINES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CACHE_LINES; k++) begin
        valid_q[k] <= 1'b0;
        dirty_q[k] <= 1'b0;
        page_q[k]  <= '0;
      end
    end else if (upd_i.fill_done) begin
      valid_q[idx_i] <= 1'b1;
      dirty_q[idx_i] <= upd_i.fill_dirty;
      page_q[idx_i]  <= page_i;
    end else if (upd_i.mark_dirty) begin
      dirty_q[idx_i] <= 1'b1;
    end
  end

  assign valid_o = valid_q[idx_i];
  assign dirty_o = dirty_q[idx_i];
  assign page_o  = page_q[idx_i];

endmodule

/* rtl/disk_page_cache_access_top.sv */
// Disk page cache: reads or writes 1 to 4 little-endian bytes of an emulated disk
// through a direct-mapped write-back page cache. After reset the backing store is
// swept to zero, one byte a cycle, over all DISK_PAGES*PAGE_BYTES bytes, during
// which no item is taken. An item of size zero or beyond the pages in use goes to
// its result without touching the cache. Each miss fills the whole page byte by
// byte and, if the victim is dirty, first writes it back the same way, all through
// the single byte port of each memory. A finished result waits in an output register
// while the next item is taken. PAGE_BYTES, CACHE_LINES and DISK_PAGES must be
// powers of two.
// depends on dpc_pkg, dpc_ram, dpc_meta
module disk_page_cache_access_top import dpc_pkg::*; #(
  parameter int PAGE_BYTES  = 4096,
  parameter int CACHE_LINES = 8,
  parameter int DISK_PAGES  = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [6:0]  cfg_wr_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [17:0] byte_address_i,
  input  logic [2:0]  access_size_i,
  input  logic [31:0] write_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_data_o,
  output logic [1:0]  page_fills_o,
  output logic [1:0]  page_writebacks_o,
  output logic        access_error_o
);

  localparam int OFS_W   = $clog2(PAGE_BYTES);
  localparam int IDX_W   = (CACHE_LINES > 1) ? $clog2(CACHE_LINES) : 1;
  localparam int PAGE_W  = (DISK_PAGES > 1) ? $clog2(DISK_PAGES) : 1;
  localparam int LDEPTH  = CACHE_LINES * PAGE_BYTES;
  localparam int BDEPTH  = DISK_PAGES * PAGE_BYTES;
  localparam int LA_W    = $clog2(LDEPTH);
  localparam int BA_W    = $clog2(BDEPTH);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_BYTE  = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_WB    = 3'd4;
  localparam logic [2:0] ST_FILL  = 3'd5;
  localparam logic [2:0] ST_RD    = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [6:0]        pages_q;
  logic              op_q, op_d;
  logic [17:0]       addr_q, addr_d;
  logic [2:0]        size_q, size_d;
  logic [31:0]       wdata_q, wdata_d;
  logic [2:0]        i_q, i_d;
  logic [PAGE_W-1:0] cur_page_q, cur_page_d;
  logic              have_page_q, have_page_d;
  logic [PAGE_W-1:0] victim_q, victim_d;
  logic [OFS_W:0]    cnt_q, cnt_d;
  logic [BA_W-1:0]   clr_q, clr_d;
  logic [31:0]       rdata_q, rdata_d;
  logic [1:0]        fills_q, fills_d;
  logic [1:0]        wbs_q, wbs_d;
  logic              err_q, err_d;

  logic              out_valid_q, out_valid_d;
  logic [31:0]       out_rdata_q, out_rdata_d;
  logic [1:0]        out_fills_q, out_fills_d;
  logic [1:0]        out_wbs_q, out_wbs_d;
  logic              out_err_q, out_err_d;

  logic              accept;
  logic [2:0]        in_size_sat;
  logic [18:0]       in_last;
  logic [18:0]       limit;
  logic [18:0]       last;
  logic [18:0]       byte_a;
  logic [PAGE_W-1:0] page_a;
  logic [OFS_W-1:0]  ofs_a;
  logic [IDX_W-1:0]  cur_idx;
  logic [OFS_W:0]    cnt_m1;
  logic              cnt_end;

  logic              meta_valid, meta_dirty;
  logic [PAGE_W-1:0] meta_page;
  dpc_meta_upd_t     meta_upd;

  logic              l_we;
  logic [LA_W-1:0]   l_waddr, l_raddr;
  logic [7:0]        l_wdata, l_rdata;
  logic              b_we;
  logic [BA_W-1:0]   b_waddr, b_raddr;
  logic [7:0]        b_wdata, b_rdata;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  assign in_size_sat = (access_size_i > MAX_SIZE) ? MAX_SIZE : access_size_i;
  assign in_last     = 19'(byte_address_i) + 19'(in_size_sat) - 19'd1;
  assign limit       = (19'(pages_q) > 19'(DISK_PAGES)) ? 19'(DISK_PAGES) : 19'(pages_q);

  assign last    = 19'(addr_q) + 19'(size_q) - 19'd1;
  assign byte_a  = (op_q == OP_READ) ? (last - 19'(i_q)) : (19'(addr_q) + 19'(i_q));
  assign page_a  = PAGE_W'(byte_a >> OFS_W);
  assign ofs_a   = byte_a[OFS_W-1:0];
  assign cur_idx = IDX_W'(32'(cur_page_q) % CACHE_LINES);
  assign cnt_m1  = cnt_q - 1'b1;
  assign cnt_end = (cnt_q == (OFS_W+1)'(PAGE_BYTES));

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    addr_d      = addr_q;
    size_d      = size_q;
    wdata_d     = wdata_q;
    i_d         = i_q;
    cur_page_d  = cur_page_q;
    have_page_d = have_page_q;
    victim_d    = victim_q;
    cnt_d       = cnt_q;
    clr_d       = clr_q;
    rdata_d     = rdata_q;
    fills_d     = fills_q;
    wbs_d       = wbs_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_rdata_d = out_rdata_q;
    out_fills_d = out_fills_q;
    out_wbs_d   = out_wbs_q;
    out_err_d   = out_err_q;
    meta_upd    = '0;
    l_we        = 1'b0;
    l_waddr     = (LA_W'(cur_idx) << OFS_W) | LA_W'(ofs_a);
    l_wdata     = wdata_q[8*i_q[1:0] +: 8] & BYTE_MASK;
    l_raddr     = (LA_W'(cur_idx) << OFS_W) | LA_W'(ofs_a);
    b_we        = 1'b0;
    b_waddr     = clr_q;
    b_wdata     = '0;
    b_raddr     = (BA_W'(cur_page_q) << OFS_W) | BA_W'(cnt_q[OFS_W-1:0]);

    unique case (state_q)
      ST_CLEAR: begin
        b_we  = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == BA_W'(BDEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          op_d        = operation_i;
          addr_d      = byte_address_i;
          size_d      = in_size_sat;
          wdata_d     = write_data_i;
          i_d         = '0;
          have_page_d = 1'b0;
          rdata_d     = '0;
          fills_d     = '0;
          wbs_d       = '0;
          err_d       = 1'b0;
          if (in_size_sat == 3'd0) begin
            state_d = ST_DONE;
          end else if ((in_last >> OFS_W) >= limit) begin
            err_d   = 1'b1;
            state_d = ST_DONE;
          end else begin
            state_d = ST_BYTE;
          end
        end
      end
      ST_BYTE: begin
        if (i_q == size_q) begin
          state_d = ST_DONE;
        end else if (!have_page_q || (page_a != cur_page_q)) begin
          cur_page_d  = page_a;
          have_page_d = 1'b1;
          state_d     = ST_CHECK;
        end else if (op_q == OP_READ) begin
          state_d = ST_RD;
        end else begin
          l_we = 1'b1;
          i_d  = i_q + 1'b1;
        end
      end
      ST_CHECK: begin
        cnt_d = '0;
        if (meta_valid && (meta_page == cur_page_q)) begin
          meta_upd.mark_dirty = (op_q == OP_WRITE);
          state_d             = ST_BYTE;
        end else if (meta_valid && meta_dirty) begin
          victim_d = meta_page;
          state_d  = ST_WB;
        end else begin
          state_d = ST_FILL;
        end
      end
      ST_WB: begin
        l_raddr = (LA_W'(cur_idx) << OFS_W) | LA_W'(cnt_q[OFS_W-1:0]);
        b_we    = (cnt_q != '0);
        b_waddr = (BA_W'(victim_q) << OFS_W) | BA_W'(cnt_m1[OFS_W-1:0]);
        b_wdata = l_rdata;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_end) begin
          wbs_d   = wbs_q + 1'b1;
          cnt_d   = '0;
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        l_we    = (cnt_q != '0);
        l_waddr = (LA_W'(cur_idx) << OFS_W) | LA_W'(cnt_m1[OFS_W-1:0]);
        l_wdata = b_rdata;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_end) begin
          fills_d             = fills_q + 1'b1;
          meta_upd.fill_done  = 1'b1;
          meta_upd.fill_dirty = (op_q == OP_WRITE);
          state_d             = ST_BYTE;
        end
      end
      ST_RD: begin
        rdata_d = {rdata_q[23:0], l_rdata};
        i_d     = i_q + 1'b1;
        state_d = ST_BYTE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_rdata_d = rdata_q;
          out_fills_d = fills_q;
          out_wbs_d   = wbs_q;
          out_err_d   = err_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      pages_q     <= 7'd64;
      clr_q       <= '0;
      have_page_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      have_page_q <= have_page_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr_en_i) begin
        pages_q <= cfg_wr_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    addr_q      <= addr_d;
    size_q      <= size_d;
    wdata_q     <= wdata_d;
    i_q         <= i_d;
    cur_page_q  <= cur_page_d;
    victim_q    <= victim_d;
    cnt_q       <= cnt_d;
    rdata_q     <= rdata_d;
    fills_q     <= fills_d;
    wbs_q       <= wbs_d;
    err_q       <= err_d;
    out_rdata_q <= out_rdata_d;
    out_fills_q <= out_fills_d;
    out_wbs_q   <= out_wbs_d;
    out_err_q   <= out_err_d;
  end

  dpc_meta #(
    .CACHE_LINES (CACHE_LINES),
    .IDX_W       (IDX_W),
    .PAGE_W      (PAGE_W)
  ) u_meta (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .idx_i   (cur_idx),
    .page_i  (cur_page_q),
    .upd_i   (meta_upd),
    .valid_o (meta_valid),
    .dirty_o (meta_dirty),
    .page_o  (meta_page)
  );

  dpc_ram #(
    .WIDTH (8),
    .DEPTH (LDEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

  dpc_ram #(
    .WIDTH (8),
    .DEPTH (BDEPTH)
  ) u_store_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  assign out_valid_o       = out_valid_q;
  assign read_data_o       = out_rdata_q;
  assign page_fills_o      = out_fills_q;
  assign page_writebacks_o = out_wbs_q;
  assign access_error_o    = out_err_q;

  a_rd_only_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |-> (op_q == OP_READ))
    else $error("byte read on a write item");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && access_error_o) |->
      (page_fills_o == 2'd0 && page_writebacks_o == 2'd0 && read_data_o == 32'd0))
    else $error("error item with side effects");

  a_wb_le_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> (wbs_q <= fills_q && fills_q <= 2'd2))
    else $error("fill or writeback count out of range");

  a_fill_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL && cnt_end) |=> (meta_valid && meta_page == cur_page_q))
    else $error("line not valid after fill");

endmodule

/* tb/testbench.sv */
// self-checking testbench for disk_page_cache_access_top: a clocked driver and monitor
// with random idling and stalls, checked against an in-bench page cache predictor
// depends on dpc_pkg and the disk_page_cache_access_top rtl
`timescale 1ns / 1ps

module testbench;
  import dpc_pkg::*;

  localparam int PG_BYTES    = 4096;
  localparam int NUM_LINES   = 8;
  localparam int NUM_PAGES   = 64;
  localparam int HOLD_CYCLES = 400;

  typedef enum logic [1:0] {K_ACCESS, K_LIMIT, K_DRAIN} job_kind_e;

  typedef struct {
    job_kind_e   kind;
    logic        op;
    logic [17:0] addr;
    logic [2:0]  size;
    logic [31:0] data;
    logic [6:0]  limit;
  } job_t;

  typedef struct {
    logic [31:0] rdata;
    logic [1:0]  fills;
    logic [1:0]  wbs;
    logic        err;
  } access_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_wr_en_i;
  logic [6:0]  cfg_wr_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        operation_i;
  logic [17:0] byte_address_i;
  logic [2:0]  access_size_i;
  logic [31:0] write_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] read_data_o;
  logic [1:0]  page_fills_o;
  logic [1:0]  page_writebacks_o;
  logic        access_error_o;

  disk_page_cache_access_top u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_wr_en_i       (cfg_wr_en_i),
    .cfg_wr_data_i     (cfg_wr_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .operation_i       (operation_i),
    .byte_address_i    (byte_address_i),
    .access_size_i     (access_size_i),
    .write_data_i      (write_data_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .read_data_o       (read_data_o),
    .page_fills_o      (page_fills_o),
    .page_writebacks_o (page_writebacks_o),
    .access_error_o    (access_error_o)
  );

  // predictor state
  bit [7:0]    disk_img [NUM_PAGES*PG_BYTES];
  bit [7:0]    line_img [NUM_LINES*PG_BYTES];
  bit          line_valid [NUM_LINES];
  bit          line_dirty [NUM_LINES];
  int unsigned line_page  [NUM_LINES];
  int unsigned page_limit = 64;

  job_t           job_queue [$];
  access_result_t expected_results [$];
  int             n_errors = 0;
  int             n_results = 0;
  int unsigned    hot_page [NUM_LINES];

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int unsigned bring_in(input int unsigned page,
                                           inout logic [1:0] fills,
                                           inout logic [1:0] wbs);
    int unsigned idx = page % NUM_LINES;
    if (line_valid[idx] && line_page[idx] == page) return idx;
    if (line_valid[idx] && line_dirty[idx]) begin
      for (int b = 0; b < PG_BYTES; b++)
        disk_img[line_page[idx]*PG_BYTES + b] = line_img[idx*PG_BYTES + b];
      wbs++;
    end
    for (int b = 0; b < PG_BYTES; b++)
      line_img[idx*PG_BYTES + b] = disk_img[page*PG_BYTES + b];
    line_valid[idx] = 1'b1;
    line_dirty[idx] = 1'b0;
    line_page[idx]  = page;
    fills++;
    return idx;
  endfunction

  function automatic void cache_access(input job_t j);
    access_result_t r;
    int unsigned lim, size, last, cur, idx, page, a;
    r = '{32'd0, 2'd0, 2'd0, 1'b0};
    lim  = page_limit > NUM_PAGES ? NUM_PAGES : page_limit;
    size = j.size > MAX_SIZE ? MAX_SIZE : j.size;
    cur  = 32'hFFFF_FFFF;
    idx  = 0;
    if (size != 0) begin
      last = j.addr + size - 1;
      if (last / PG_BYTES >= lim) begin
        r.err = 1'b1;
      end else if (j.op == OP_READ) begin
        for (int i = 0; i < size; i++) begin
          a = last - i;
          page = a / PG_BYTES;
          if (page != cur) begin
            idx = bring_in(page, r.fills, r.wbs);
            cur = page;
          end
          r.rdata = (r.rdata << 8) | line_img[idx*PG_BYTES + a % PG_BYTES];
        end
      end else begin
        for (int i = 0; i < size; i++) begin
          a = j.addr + i;
          page = a / PG_BYTES;
          if (page != cur) begin
            idx = bring_in(page, r.fills, r.wbs);
            line_dirty[idx] = 1'b1;
            cur = page;
          end
          line_img[idx*PG_BYTES + a % PG_BYTES] = 8'((j.data >> (8 * i)) & BYTE_MASK);
        end
      end
    end
    expected_results.insert(expected_results.size(), r);
  endfunction

  // driver
  job_t        cur_job;
  int unsigned send_gap = 0;
  bit          send_burst = 0;

  always @(posedge clk_i) begin
    logic offer;
    logic cfg_we;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      cfg_wr_en_i <= 1'b0;
    end else begin
      offer  = in_valid_i;
      cfg_we = 1'b0;
      if (in_valid_i && !in_stall_o) begin
        cache_access(cur_job);
        offer = 1'b0;
        if ($urandom_range(0, 19) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 17);
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (job_queue.size() > 0) begin
          if (job_queue[0].kind == K_LIMIT) begin
            if (expected_results.size() == 0 && !cfg_wr_en_i) begin
              cfg_we = 1'b1;
              cfg_wr_data_i <= job_queue[0].limit;
              page_limit = job_queue[0].limit;
              void'(job_queue.pop_front());
            end
          end else if (job_queue[0].kind == K_DRAIN) begin
            if (expected_results.size() == 0) void'(job_queue.pop_front());
          end else if (!cfg_wr_en_i) begin
            cur_job = job_queue.pop_front();
            offer = 1'b1;
            operation_i    <= cur_job.op;
            byte_address_i <= cur_job.addr;
            access_size_i  <= cur_job.size;
            write_data_i   <= cur_job.data;
          end
        end
      end
      in_valid_i  <= offer;
      cfg_wr_en_i <= cfg_we;
    end
  end

  // monitor
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          recv_burst = 0;

  always @(posedge clk_i) begin
    access_result_t e;
    logic stall;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        if (expected_results.size() == 0) begin
          $error("unexpected result item");
          n_errors++;
        end else begin
          e = expected_results.pop_front();
          if (read_data_o !== e.rdata) begin
            $error("read_data expected %h got %h", e.rdata, read_data_o);
            n_errors++;
          end
          if (page_fills_o !== e.fills) begin
            $error("page_fills expected %0d got %0d", e.fills, page_fills_o);
            n_errors++;
          end
          if (page_writebacks_o !== e.wbs) begin
            $error("page_writebacks expected %0d got %0d", e.wbs, page_writebacks_o);
            n_errors++;
          end
          if (access_error_o !== e.err) begin
            $error("access_error expected %0d got %0d", e.err, access_error_o);
            n_errors++;
          end
        end
        if ($urandom_range(0, 19) == 0) recv_burst = !recv_burst;
        stall_left = recv_burst ? 0 : $urandom_range(0, 17);
        if (n_results == 60) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        stall = 1'b1;
      end else begin
        stall = 1'b0;
      end
      out_stall_i <= stall;
    end
  end

  function automatic void add_access(input logic op, input logic [17:0] addr,
                                     input logic [2:0] size, input logic [31:0] data);
    job_queue.insert(job_queue.size(), '{K_ACCESS, op, addr, size, data, 7'd0});
  endfunction

  function automatic void add_limit(input logic [6:0] v);
    job_queue.insert(job_queue.size(), '{K_LIMIT, 1'b0, 18'd0, 3'd0, 32'd0, v});
  endfunction

  function automatic void add_random_access();
    int unsigned page, offs, r;
    logic [2:0] size;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      page = $urandom_range(0, NUM_PAGES - 1);
      hot_page[page % NUM_LINES] = page;
    end else begin
      page = hot_page[$urandom_range(0, NUM_LINES - 1)];
    end
    r = $urandom_range(0, 99);
    size = r < 3 ? 3'd0 : r < 8 ? 3'($urandom_range(5, 7)) : 3'($urandom_range(1, 4));
    if ($urandom_range(0, 11) == 0) begin
      offs = $urandom_range(PG_BYTES - 3, PG_BYTES - 1);
      if (page < NUM_PAGES - 1) hot_page[(page + 1) % NUM_LINES] = page + 1;
    end else if ($urandom_range(0, 3) == 0) begin
      offs = $urandom_range(0, 15);
    end else begin
      offs = $urandom_range(0, PG_BYTES - 1);
    end
    add_access(1'($urandom_range(0, 1)), 18'(page * PG_BYTES + offs), size, $urandom());
  endfunction

  initial begin
    int unsigned limits [6];
    in_valid_i     = 1'b0;
    cfg_wr_en_i    = 1'b0;
    cfg_wr_data_i  = 7'd0;
    operation_i    = 1'b0;
    byte_address_i = '0;
    access_size_i  = '0;
    write_data_i   = '0;
    out_stall_i    = 1'b0;
    rst_ni         = 1'b0;
    limits = '{64, 127, 64, 5, 64, 1};
    for (int i = 0; i < NUM_LINES; i++) hot_page[i] = i;

    // directed: extremes, crossings, dirty eviction, saturated and zero sizes
    add_limit(7'd127);
    add_access(OP_READ,  18'd0, 3'd1, 32'd0);
    add_access(OP_WRITE, 18'd0, 3'd4, 32'hA1B2_C3D4);
    add_access(OP_READ,  18'd0, 3'd4, 32'd0);
    add_access(OP_READ,  18'd0, 3'd0, 32'hFFFF_FFFF);
    add_access(OP_WRITE, 18'd2, 3'd7, 32'h5566_7788);
    add_access(OP_READ,  18'd1, 3'd5, 32'd0);
    add_access(OP_WRITE, 18'd4094, 3'd4, 32'hDEAD_BEEF);
    add_access(OP_READ,  18'd4094, 3'd4, 32'd0);
    add_access(OP_READ,  18'h3FFFF, 3'd1, 32'd0);
    add_access(OP_WRITE, 18'h3FFFC, 3'd4, 32'hFFFF_FFFF);
    add_access(OP_READ,  18'h3FFFF, 3'd2, 32'd0);
    add_access(OP_WRITE, 18'h3FFFF, 3'd3, 32'h1234_5678);
    add_access(OP_WRITE, 18'(8 * PG_BYTES + 5), 3'd2, 32'h0000_CAFE);
    add_access(OP_READ,  18'd0, 3'd4, 32'd0);
    add_access(OP_READ,  18'h3FFFC, 3'd4, 32'd0);
    add_limit(7'd0);
    add_access(OP_READ,  18'd0, 3'd1, 32'd0);
    add_access(OP_WRITE, 18'd0, 3'd0, 32'd0);
    add_limit(7'd1);
    add_access(OP_READ,  18'd4095, 3'd1, 32'd0);
    add_access(OP_WRITE, 18'd4095, 3'd2, 32'h0000_ABCD);

    for (int p = 0; p < 6; p++) begin
      add_limit(7'(limits[p]));
      for (int i = 0; i < (limits[p] < 8 ? 40 : 130); i++) begin
        add_random_access();
        if (p == 2 && i == 60) begin
          job_queue.insert(job_queue.size(), '{K_DRAIN, 1'b0, 18'd0, 3'd0, 32'd0, 7'd0});
        end
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (job_queue.size() != 0 || in_valid_i || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (100) @(posedge clk_i);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #400ms;
    $display("tb: failure");
    $finish;
  end

endmodule
